### sv/drip_pkg.sv
`timescale 1ns / 1ps
// Package for the distinct random index picker: widths, beat types and the
// urn lookup over the short list of displaced slots. No dependencies.
package drip_pkg;

  localparam int MaxPop       = 1024;
  localparam int IdxW         = 10;
  localparam int PopW         = 11;
  localparam int FracW        = 16;
  localparam int NumFields    = 4;
  localparam int OvN          = NumFields + 1;
  localparam int PickCountDef = 4;
  localparam logic [PopW-1:0] PopReset = PopW'(16);

  typedef logic [IdxW-1:0] idx_t;

  // One displaced urn slot: slot now holds val instead of its own index.
  typedef struct packed {
    logic vld;
    idx_t slot;
    idx_t val;
  } ov_t;

  typedef struct packed {
    logic                  bad;
    idx_t                  k;
    idx_t [NumFields-1:0]  slot;
    idx_t [NumFields-1:0]  pick;
    ov_t  [OvN-1:0]        ov;
  } beat_t;

  // The urn is the identity except at the displaced slots; later entries win.
  function automatic idx_t urn_read(input ov_t [OvN-1:0] ov, input idx_t s);
    idx_t r;
    r = s;
    for (int i = 0; i < OvN; i++) begin
      if (ov[i].vld && (ov[i].slot == s)) begin
        r = ov[i].val;
      end
    end
    return r;
  endfunction

endpackage

### sv/drip_slot_mul.sv
`timescale 1ns / 1ps
// Entry stage: clamps the population, checks the request and scales the
// random fraction of each pick to its urn slot. Depends on drip_pkg.
module drip_slot_mul import drip_pkg::*; #(
  parameter int NumPicks = PickCountDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [PopW-1:0]                     pop_size_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  idx_t                                avoid_i,
  input  logic [NumFields-1:0][FracW-1:0]     frac_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output beat_t                               beat_o
);

  localparam int ProdW = FracW + IdxW;

  logic [PopW-1:0]  n;
  idx_t             k0;
  logic [ProdW-1:0] prod [NumFields];
  beat_t            beat_d, beat_q;
  logic             vld_q;

  assign n  = (pop_size_i > PopW'(MaxPop)) ? PopW'(MaxPop) : pop_size_i;
  assign k0 = IdxW'(n - PopW'(1));

  always_comb begin
    beat_d     = '0;
    beat_d.bad = ({1'b0, avoid_i} >= n) || (n < PopW'(NumPicks + 1));
    beat_d.k   = k0;
    // Taking out the avoided index moves the last entry into its slot.
    beat_d.ov[0] = '{vld: 1'b1, slot: avoid_i, val: k0};
    for (int p = 0; p < NumFields; p++) begin
      prod[p] = '0;
      if (p < NumPicks) begin
        prod[p] = ProdW'(frac_i[p]) * ProdW'(k0 - IdxW'(p));
      end
      beat_d.slot[p] = prod[p][FracW +: IdxW];
    end
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign beat_o      = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= beat_d;
    end
  end

endmodule

### sv/drip_pick_stage.sv
`timescale 1ns / 1ps
// One pick of the partial shuffle: reads the chosen slot, refills it with
// the last urn entry and shrinks the urn. Depends on drip_pkg.
module drip_pick_stage import drip_pkg::*; #(
  parameter int Stage = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  beat_t beat_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output beat_t beat_o
);

  idx_t  last;
  beat_t beat_d, beat_q;
  logic  vld_q;

  assign last = beat_i.k - IdxW'(1);

  always_comb begin
    beat_d = beat_i;
    beat_d.pick[Stage] = beat_i.bad ? '0 : urn_read(beat_i.ov, beat_i.slot[Stage]);
    beat_d.ov[Stage+1] = '{vld: 1'b1, slot: beat_i.slot[Stage],
                           val: urn_read(beat_i.ov, last)};
    beat_d.k = last;
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign beat_o      = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= beat_d;
    end
  end

endmodule

### sv/distinct_random_index_picker.sv
`timescale 1ns / 1ps
// Top level of the distinct random index picker: pop_size register, scaling
// stage and one pick stage per pick. Depends on drip_pkg and its submodules.

// Takes one request per cycle while the output is not stalled: one stage
// scales the random fraction of each pick to its urn slot with one multiplier
// per pick, all in parallel; then each pick has a stage of its own that looks
// up and refills one slot. The urn is never stored; it is the identity apart
// from a few displaced slots that travel with the beat. Stalls on the output
// back up through the stages without dropping or repeating a beat, and empty
// stages fill while the output waits.
module distinct_random_index_picker import drip_pkg::*; #(
  parameter int PICK_COUNT = PickCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [PopW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  idx_t            avoid_index_i,
  input  logic [FracW-1:0] rand_a_i,
  input  logic [FracW-1:0] rand_b_i,
  input  logic [FracW-1:0] rand_c_i,
  input  logic [FracW-1:0] rand_d_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output idx_t            pick_a_o,
  output idx_t            pick_b_o,
  output idx_t            pick_c_o,
  output idx_t            pick_d_o,
  output logic            bad_request_o
);

  localparam int NumPicks = (PICK_COUNT < NumFields) ? PICK_COUNT : NumFields;

  logic [PopW-1:0]                 pop_size_q;
  logic [NumFields-1:0][FracW-1:0] frac;
  beat_t                           stage_data [NumPicks+1];
  logic [NumPicks:0]               stage_vld;
  logic [NumPicks:0]               stage_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q <= PopReset;
    end else if (cfg_we_i) begin
      pop_size_q <= cfg_wdata_i;
    end
  end

  assign frac[0] = rand_a_i;
  assign frac[1] = rand_b_i;
  assign frac[2] = rand_c_i;
  assign frac[3] = rand_d_i;

  drip_slot_mul #(
    .NumPicks(NumPicks)
  ) u_slot_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_size_i (pop_size_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .avoid_i    (avoid_index_i),
    .frac_i     (frac),
    .out_valid_o(stage_vld[0]),
    .out_ready_i(stage_rdy[0]),
    .beat_o     (stage_data[0])
  );

  for (genvar p = 0; p < NumPicks; p++) begin : g_pick
    drip_pick_stage #(
      .Stage(p)
    ) u_pick (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (stage_vld[p]),
      .in_ready_o (stage_rdy[p]),
      .beat_i     (stage_data[p]),
      .out_valid_o(stage_vld[p+1]),
      .out_ready_i(stage_rdy[p+1]),
      .beat_o     (stage_data[p+1])
    );
  end

  assign stage_rdy[NumPicks] = out_ready_i;
  assign out_valid_o   = stage_vld[NumPicks];
  assign pick_a_o      = stage_data[NumPicks].pick[0];
  assign pick_b_o      = stage_data[NumPicks].pick[1];
  assign pick_c_o      = stage_data[NumPicks].pick[2];
  assign pick_d_o      = stage_data[NumPicks].pick[3];
  assign bad_request_o = stage_data[NumPicks].bad;

endmodule

### sv/drip_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the distinct random index picker, bound to the top
// level below. Depends on drip_pkg.
module drip_checker import drip_pkg::*; #(
  parameter int PICK_COUNT = PickCountDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input idx_t pick_a_o,
  input idx_t pick_b_o,
  input idx_t pick_c_o,
  input idx_t pick_d_o,
  input logic bad_request_o
);

  // A result beat that is not taken stays on the port.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pick_a_o) && $stable(pick_d_o)
                                   && $stable(bad_request_o))
    else $error("result beat changed while stalled");

  // A refused request carries no picks.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_request_o |-> (pick_a_o == '0) && (pick_b_o == '0)
                                     && (pick_c_o == '0) && (pick_d_o == '0))
    else $error("refused request shows picks");

  // Drawing without replacement never repeats an index; this compares a with b, a with d and c with d.
  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_request_o |->
      (PICK_COUNT < 2) || ((pick_a_o != pick_b_o)
      && ((PICK_COUNT < 4) || ((pick_a_o != pick_d_o) && (pick_c_o != pick_d_o)))))
    else $error("repeated index in one result");

endmodule

bind distinct_random_index_picker drip_checker #(
  .PICK_COUNT(PICK_COUNT)
) u_drip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pick_a_o     (pick_a_o),
  .pick_b_o     (pick_b_o),
  .pick_c_o     (pick_c_o),
  .pick_d_o     (pick_d_o),
  .bad_request_o(bad_request_o)
);
